FILE: rtl/core/ksi_pkg.sv
// Package with the shared types, character codes and keyword table of the keyword space inserter.
`default_nettype none
package ksi_pkg;

  localparam int unsigned WORD_MAX = 6;
  localparam int unsigned KW_COUNT = 7;
  localparam int unsigned LANES    = 8;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DQ    = 8'h22;
  localparam logic [7:0] CHAR_SQ    = 8'h27;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_US    = 8'h5F;

  // Keyword text, first character in entry 0, unused characters zero.
  localparam logic [KW_COUNT-1:0][WORD_MAX-1:0][7:0] KW_TEXT = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h6F, 8'h64},  // do
    '{8'h00, 8'h00, 8'h65, 8'h73, 8'h61, 8'h63},  // case
    '{8'h6E, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72},  // return
    '{8'h68, 8'h63, 8'h74, 8'h69, 8'h77, 8'h73},  // switch
    '{8'h00, 8'h65, 8'h6C, 8'h69, 8'h68, 8'h77},  // while
    '{8'h00, 8'h00, 8'h00, 8'h72, 8'h6F, 8'h66},  // for
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h69}   // if
  };
  localparam logic [KW_COUNT-1:0][2:0] KW_LEN = '{
    3'd2, 3'd4, 3'd6, 3'd6, 3'd5, 3'd3, 3'd2
  };

  typedef enum logic [2:0] {
    MODE_CODE = 3'b001,
    MODE_LIT  = 3'b010,
    MODE_CMT  = 3'b100
  } lex_mode_e;

  typedef enum logic [2:0] {
    WS_NONE = 3'b001,
    WS_HELD = 3'b010,
    WS_LONG = 3'b100
  } word_status_e;

  // One burst of output bytes caused by a single input word.
  typedef struct packed {
    logic [LANES-1:0][7:0] bytes;
    logic [3:0]            count;
  } burst_t;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CHAR_US);
  endfunction

  function automatic logic is_keyword(input logic [WORD_MAX-1:0][7:0] wbuf,
                                      input logic [2:0] len);
    logic hit;
    logic same;
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = (KW_LEN[k] == len);
      for (int j = 0; j < WORD_MAX; j++) begin
        if ((3'(j) < len) && (KW_TEXT[k][j] != wbuf[j])) begin
          same = 1'b0;
        end
      end
      hit = hit | same;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ksi_front.sv
// Front end: lexes each input word and builds the burst of output bytes it causes.
`default_nettype none
module ksi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    line_byte_i,
  input  wire logic          end_of_line_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output ksi_pkg::burst_t    burst_o
);
  import ksi_pkg::*;

  lex_mode_e                  mode_q, mode_d;
  word_status_e               status_q, status_d;
  logic                       quote_q, quote_d;
  logic                       escape_q, escape_d;
  logic                       slash_q, slash_d;
  logic [2:0]                 len_q, len_d;
  logic [WORD_MAX-1:0][7:0]   word_q, word_d;

  logic       accept;
  logic [3:0] hlen;
  logic       sp;
  logic       tail;
  logic [7:0] tail_byte;
  logic [3:0] tail_pos;
  logic [7:0] c;

  assign c          = line_byte_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d    = mode_q;
    status_d  = status_q;
    quote_d   = quote_q;
    escape_d  = escape_q;
    slash_d   = slash_q;
    len_d     = len_q;
    word_d    = word_q;
    hlen      = 4'd0;
    sp        = 1'b0;
    tail      = 1'b1;
    tail_byte = c;
    if (end_of_line_i) begin
      hlen      = (status_q == WS_HELD) ? {1'b0, len_q} : 4'd0;
      tail_byte = CHAR_NL;
      mode_d    = MODE_CODE;
      status_d  = WS_NONE;
      quote_d   = 1'b0;
      escape_d  = 1'b0;
      slash_d   = 1'b0;
      len_d     = 3'd0;
    end else begin
      case (mode_q)
        MODE_LIT: begin
          if (escape_q) begin
            escape_d = 1'b0;
          end else if (c == CHAR_BSL) begin
            escape_d = 1'b1;
          end else if (c == (quote_q ? CHAR_SQ : CHAR_DQ)) begin
            mode_d = MODE_CODE;
          end
        end
        MODE_CMT: begin
          tail = 1'b1;
        end
        default: begin
          slash_d = 1'b0;
          if (slash_q && (c == CHAR_SLASH)) begin
            mode_d = MODE_CMT;
          end else if (is_word_char(c)) begin
            case (status_q)
              WS_LONG: begin
                tail = 1'b1;
              end
              WS_NONE: begin
                tail      = 1'b0;
                word_d[0] = c;
                len_d     = 3'd1;
                status_d  = WS_HELD;
              end
              default: begin
                if (len_q < 3'(WORD_MAX)) begin
                  tail          = 1'b0;
                  word_d[len_q] = c;
                  len_d         = len_q + 3'd1;
                end else begin
                  hlen     = 4'(WORD_MAX);
                  len_d    = 3'd0;
                  status_d = WS_LONG;
                end
              end
            endcase
          end else begin
            if (status_q == WS_HELD) begin
              hlen = {1'b0, len_q};
              sp   = is_keyword(word_q, len_q) && (c != CHAR_SPACE) && (c != CHAR_TAB);
            end
            status_d = WS_NONE;
            len_d    = 3'd0;
            if ((c == CHAR_DQ) || (c == CHAR_SQ)) begin
              mode_d   = MODE_LIT;
              quote_d  = (c == CHAR_SQ);
              escape_d = 1'b0;
            end else if (c == CHAR_SLASH) begin
              slash_d = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign tail_pos = hlen + {3'd0, sp};

  always_comb begin
    burst_o.bytes = '0;
    for (int i = 0; i < WORD_MAX; i++) begin
      if (4'(i) < hlen) begin
        burst_o.bytes[i] = word_q[i];
      end
    end
    for (int i = 0; i < LANES; i++) begin
      if (sp && (4'(i) == hlen)) begin
        burst_o.bytes[i] = CHAR_SPACE;
      end
      if (tail && (4'(i) == tail_pos)) begin
        burst_o.bytes[i] = tail_byte;
      end
    end
    burst_o.count = tail_pos + {3'd0, tail};
  end

  assign push_o = accept && (burst_o.count != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CODE;
      status_q <= WS_NONE;
      quote_q  <= 1'b0;
      escape_q <= 1'b0;
      slash_q  <= 1'b0;
      len_q    <= 3'd0;
    end else if (accept) begin
      mode_q   <= mode_d;
      status_q <= status_d;
      quote_q  <= quote_d;
      escape_q <= escape_d;
      slash_q  <= slash_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ksi_queue.sv
// Short queue of output bursts between the front end and the serializer.
`default_nettype none
module ksi_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ksi_pkg::burst_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output ksi_pkg::burst_t       head_o
);
  import ksi_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  burst_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ksi_back.sv
// Back end: serializes the burst at the head of the queue one output word per cycle while out_ready_i is high.
`default_nettype none
module ksi_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire ksi_pkg::burst_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);
  import ksi_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o = head_valid_i;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign out_last_o  = ({1'b0, idx_q} == (head_i.count - 4'd1));
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = out_last_o ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/keyword_space_inserter_top.sv
// Top level of the keyword space inserter: front end, burst queue and serializer.
//
//  Channel  Signals                                     Direction
//  in       in_valid_i, in_ready_o, line_byte_i,        into block
//           end_of_line_i
//  out      out_valid_o, out_ready_i, out_byte_o,       out of block
//           out_last_o
//
// The front end takes one input word per cycle while the burst queue has room.
// An input word causes zero to eight output words, sent one per cycle by the serializer while out_ready_i is high.
// With the queue empty, the first output word of a burst appears the cycle after its input word is taken.
// Reset clears the lexer state and empties the queue; no clearing pass is needed.
// Output stalls fill the queue of QUEUE_DEPTH bursts before the input side stalls.
`default_nettype none
module keyword_space_inserter_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] line_byte_i,
  input  wire logic       end_of_line_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import ksi_pkg::*;

  burst_t push_burst;
  burst_t head_burst;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;

  ksi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .burst_o       (push_burst)
  );

  ksi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_burst),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_burst)
  );

  ksi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_burst),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ksi_checker.sv
// Port-level checker for the keyword space inserter and its bind to the top level.
`default_nettype none
module ksi_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       out_last_o
);
  import ksi_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(out_last_o))
    else $error("output word changed while stalled");

  // Only held word characters and an inserted space can precede the last word of a burst.
  a_inner_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> is_word_char(out_byte_o) || (out_byte_o == CHAR_SPACE))
    else $error("unexpected byte inside a burst");

  // With no burst pending the queue is empty, so the input is always ready.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with nothing pending");

endmodule

bind keyword_space_inserter_top ksi_checker u_ksi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
`default_nettype wire

FILE: test/tb_keyword_space_inserter_top.sv
// Testbench for the keyword space inserter: directed and random source lines checked word by word.
module tb_keyword_space_inserter_top;
  import ksi_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       pinned;
    logic [7:0] pinned_ch;
  } stim_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] line_byte_i;
  logic       end_of_line_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  keyword_space_inserter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o)
  );

  localparam int NUM_ROWS = 24;
  localparam int NUM_RANDOM = 320;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, CHAR_NL},
    '{8'h00, 1'b0, 1'b1, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 8'hFF},
    '{"i", 1'b0, 1'b0, 8'h00},
    '{"f", 1'b0, 1'b0, 8'h00},
    '{"(", 1'b0, 1'b0, 8'h00},
    '{"d", 1'b0, 1'b0, 8'h00},
    '{"o", 1'b0, 1'b0, 8'h00},
    '{CHAR_DQ, 1'b0, 1'b0, 8'h00},
    '{CHAR_BSL, 1'b0, 1'b0, 8'h00},
    '{CHAR_DQ, 1'b0, 1'b0, 8'h00},
    '{CHAR_DQ, 1'b0, 1'b0, 8'h00},
    '{"w", 1'b0, 1'b0, 8'h00},
    '{"h", 1'b0, 1'b0, 8'h00},
    '{"i", 1'b0, 1'b0, 8'h00},
    '{"l", 1'b0, 1'b0, 8'h00},
    '{"e", 1'b0, 1'b0, 8'h00},
    '{CHAR_TAB, 1'b0, 1'b0, 8'h00},
    '{CHAR_SLASH, 1'b0, 1'b0, 8'h00},
    '{"*", 1'b0, 1'b0, 8'h00},
    '{CHAR_SLASH, 1'b0, 1'b0, 8'h00},
    '{CHAR_SLASH, 1'b0, 1'b0, 8'h00},
    '{"x", 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, CHAR_NL}
  };

  string keyword_list [7] = '{"if", "for", "while", "switch", "return", "case", "do"};
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string punct_chars = "(){};=+-*<>,.!&|[]/";

  // Lexer state of the spacing predictor.
  lex_mode_e    lex_st;
  logic         quote_sq;
  logic         esc_pend;
  logic         slash_pend;
  logic [7:0]   word_buf [0:5];
  logic [2:0]   word_len;
  word_status_e word_st;

  logic [7:0] burst_q [$];
  logic [7:0] line_q [$];
  out_word_t  pending_text [$];

  int  mismatches = 0;
  int  sent_count = 0;
  bit  calm = 1'b0;
  bit  hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic logic word_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CHAR_US);
  endfunction

  task automatic close_word(input logic at_eol, input logic [7:0] c);
    string held;
    logic  kw;
    held = "";
    kw = 1'b0;
    if (word_st == WS_HELD) begin
      for (int i = 0; i < int'(word_len); i++) begin
        held = $sformatf("%s%c", held, word_buf[i]);
        burst_q.push_back(word_buf[i]);
      end
      foreach (keyword_list[k]) begin
        if (held == keyword_list[k]) kw = 1'b1;
      end
      if (kw && !at_eol && c != CHAR_SPACE && c != CHAR_TAB) begin
        burst_q.push_back(CHAR_SPACE);
      end
    end
    word_st = WS_NONE;
    word_len = 3'd0;
  endtask

  task automatic predict_spacing(input logic [7:0] c, input logic eol);
    burst_q.delete();
    if (eol) begin
      close_word(1'b1, 8'h00);
      burst_q.push_back(CHAR_NL);
      lex_st = MODE_CODE;
      quote_sq = 1'b0;
      esc_pend = 1'b0;
      slash_pend = 1'b0;
    end else if (lex_st == MODE_LIT) begin
      burst_q.push_back(c);
      if (esc_pend) begin
        esc_pend = 1'b0;
      end else if (c == CHAR_BSL) begin
        esc_pend = 1'b1;
      end else if (c == (quote_sq ? CHAR_SQ : CHAR_DQ)) begin
        lex_st = MODE_CODE;
      end
    end else if (lex_st == MODE_CMT) begin
      burst_q.push_back(c);
    end else if (slash_pend && c == CHAR_SLASH) begin
      slash_pend = 1'b0;
      lex_st = MODE_CMT;
      burst_q.push_back(c);
    end else begin
      slash_pend = 1'b0;
      if (word_char(c)) begin
        case (word_st)
          WS_LONG: burst_q.push_back(c);
          WS_NONE: begin
            word_buf[0] = c;
            word_len = 3'd1;
            word_st = WS_HELD;
          end
          default: begin
            if (word_len < 3'd6) begin
              word_buf[word_len] = c;
              word_len = word_len + 3'd1;
            end else begin
              for (int i = 0; i < 6; i++) burst_q.push_back(word_buf[i]);
              burst_q.push_back(c);
              word_len = 3'd0;
              word_st = WS_LONG;
            end
          end
        endcase
      end else begin
        close_word(1'b0, c);
        burst_q.push_back(c);
        if (c == CHAR_DQ || c == CHAR_SQ) begin
          lex_st = MODE_LIT;
          quote_sq = (c == CHAR_SQ);
          esc_pend = 1'b0;
        end else if (c == CHAR_SLASH) begin
          slash_pend = 1'b1;
        end
      end
    end
  endtask

  task automatic push_word(input logic [7:0] c, input logic eol, input logic pinned,
                           input logic [7:0] pinned_c);
    out_word_t w;
    predict_spacing(c, eol);
    if (pinned) begin
      w.ch = pinned_c;
      w.last = 1'b1;
      pending_text.push_back(w);
    end else begin
      foreach (burst_q[i]) begin
        w.ch = burst_q[i];
        w.last = (i == burst_q.size() - 1);
        pending_text.push_back(w);
      end
    end
    calm = (sent_count >= 180 && sent_count < 250);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    line_byte_i <= c;
    end_of_line_i <= eol;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sent_count++;
  endtask

  task automatic compose_line();
    string      s;
    logic [7:0] q;
    line_q.delete();
    repeat ($urandom_range(1, 7)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          s = keyword_list[$urandom_range(0, 6)];
          for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        end
        3: repeat ($urandom_range(1, 9)) line_q.push_back(word_chars[$urandom_range(0, 62)]);
        4: line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        5: line_q.push_back(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
        6: begin
          q = $urandom_range(0, 1) ? CHAR_SQ : CHAR_DQ;
          line_q.push_back(q);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 4))
              0: line_q.push_back(CHAR_BSL);
              1: line_q.push_back(q);
              2: line_q.push_back(q == CHAR_SQ ? CHAR_DQ : CHAR_SQ);
              3: line_q.push_back(word_chars[$urandom_range(0, 62)]);
              default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
          end
          if ($urandom_range(0, 4) != 0) line_q.push_back(q);
        end
        7: begin
          line_q.push_back(CHAR_SLASH);
          line_q.push_back(CHAR_SLASH);
          repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          line_q.push_back(CHAR_SLASH);
          line_q.push_back("*");
        end
        default: line_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  always @(negedge clk_i) begin
    out_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_text.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h last %b", out_byte_o, out_last_o));
      end else begin
        w = pending_text.pop_front();
        if (out_byte_o !== w.ch) begin
          flag_mismatch($sformatf("out_byte %h, predicted %h", out_byte_o, w.ch));
        end
        if (out_last_o !== w.last) begin
          flag_mismatch($sformatf("out_last %b, predicted %b", out_last_o, w.last));
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_count >= 60) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (70) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    #2000000;
    $display("[keyword_space_inserter_top] ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    line_byte_i = 8'h00;
    end_of_line_i = 1'b0;
    lex_st = MODE_CODE;
    quote_sq = 1'b0;
    esc_pend = 1'b0;
    slash_pend = 1'b0;
    word_len = 3'd0;
    word_st = WS_NONE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r]) begin
      push_word(directed_rows[r].ch, directed_rows[r].eol, directed_rows[r].pinned,
                directed_rows[r].pinned_ch);
    end
    while (sent_count < NUM_ROWS + NUM_RANDOM) begin
      compose_line();
      foreach (line_q[i]) push_word(line_q[i], 1'b0, 1'b0, 8'h00);
      push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'h00);
    end
    in_valid_i <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[keyword_space_inserter_top] OK");
    end else begin
      $display("[keyword_space_inserter_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: keyword_space_inserter_top.f
rtl/core/ksi_pkg.sv
rtl/core/ksi_front.sv
rtl/core/ksi_queue.sv
rtl/core/ksi_back.sv
rtl/core/keyword_space_inserter_top.sv
rtl/core/ksi_checker.sv
test/tb_keyword_space_inserter_top.sv
